// ===== rtl/mbrot_pkg.sv =====
// Shared types, constants and the microcode table of the escape-time iteration block.
package mbrot_pkg;

   localparam int IN_BITS    = 29;
   localparam int Z_BITS     = 35;
   localparam int LIMIT_BITS = 16;
   localparam int LO_BITS    = 18;
   localparam int HI_BITS    = Z_BITS - LO_BITS;
   localparam int MOP_BITS   = LO_BITS + 1;
   localparam int PP_BITS    = 2 * MOP_BITS;
   localparam int ACC_BITS   = 2 * Z_BITS;
   localparam int S_BITS     = 56;
   localparam int SUM_BITS   = S_BITS + 2;
   localparam int UPC_BITS   = 4;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd255;

   typedef enum logic {
      OPND_ZR,
      OPND_ZI
   } opnd_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef enum logic [1:0] {
      SH_0,
      SH_LO,
      SH_TWO_LO
   } acc_sh_type;

   typedef enum logic [1:0] {
      WR_NONE,
      WR_SR,
      WR_SI,
      WR_T
   } wr_type;

   typedef enum logic [1:0] {
      JMP_NEXT,
      JMP_TEST,
      JMP_LOOP
   } jmp_type;

   typedef struct packed {
      opnd_type   a_sel;
      logic       a_hi;
      opnd_type   b_sel;
      logic       b_hi;
      acc_op_type acc_op;
      acc_sh_type acc_sh;
      wr_type     wr;
      logic       upd;
      jmp_type    jmp;
   } ctrl_type;

   typedef struct packed {
      logic cont;
   } stat_type;

   localparam ctrl_type CTRL_IDLE = '{OPND_ZR, 1'b0, OPND_ZR, 1'b0, ACC_HOLD, SH_0,
                                      WR_NONE, 1'b0, JMP_NEXT};

   function automatic ctrl_type cw(input opnd_type a_sel, input logic a_hi,
                                   input opnd_type b_sel, input logic b_hi,
                                   input acc_op_type acc_op, input acc_sh_type acc_sh,
                                   input wr_type wr, input logic upd, input jmp_type jmp);
      ctrl_type c;
      c.a_sel  = a_sel;
      c.a_hi   = a_hi;
      c.b_sel  = b_sel;
      c.b_hi   = b_hi;
      c.acc_op = acc_op;
      c.acc_sh = acc_sh;
      c.wr     = wr;
      c.upd    = upd;
      c.jmp    = jmp;
      return c;
   endfunction

   // Each product is four partial products; each is registered in the product register before it is accumulated.
   function automatic ctrl_type ucode(input logic [UPC_BITS-1:0] step);
      ctrl_type c;
      case (step)
         4'd0: c = cw(OPND_ZR, 1'b0, OPND_ZR, 1'b0, ACC_HOLD, SH_0, WR_NONE, 1'b0, JMP_TEST);
         4'd1: c = cw(OPND_ZR, 1'b0, OPND_ZR, 1'b0, ACC_HOLD, SH_0, WR_NONE, 1'b0, JMP_NEXT);
         4'd2: c = cw(OPND_ZR, 1'b1, OPND_ZR, 1'b0, ACC_LOAD, SH_0, WR_NONE, 1'b0, JMP_NEXT);
         4'd3: c = cw(OPND_ZR, 1'b0, OPND_ZR, 1'b1, ACC_ADD, SH_LO, WR_NONE, 1'b0, JMP_NEXT);
         4'd4: c = cw(OPND_ZR, 1'b1, OPND_ZR, 1'b1, ACC_ADD, SH_LO, WR_NONE, 1'b0, JMP_NEXT);
         4'd5: c = cw(OPND_ZI, 1'b0, OPND_ZI, 1'b0, ACC_ADD, SH_TWO_LO, WR_NONE, 1'b0,
                      JMP_NEXT);
         4'd6: c = cw(OPND_ZI, 1'b1, OPND_ZI, 1'b0, ACC_LOAD, SH_0, WR_SR, 1'b0, JMP_NEXT);
         4'd7: c = cw(OPND_ZI, 1'b0, OPND_ZI, 1'b1, ACC_ADD, SH_LO, WR_NONE, 1'b0, JMP_NEXT);
         4'd8: c = cw(OPND_ZI, 1'b1, OPND_ZI, 1'b1, ACC_ADD, SH_LO, WR_NONE, 1'b0, JMP_NEXT);
         4'd9: c = cw(OPND_ZR, 1'b0, OPND_ZI, 1'b0, ACC_ADD, SH_TWO_LO, WR_NONE, 1'b0,
                      JMP_NEXT);
         4'd10: c = cw(OPND_ZR, 1'b1, OPND_ZI, 1'b0, ACC_LOAD, SH_0, WR_SI, 1'b0, JMP_NEXT);
         4'd11: c = cw(OPND_ZR, 1'b0, OPND_ZI, 1'b1, ACC_ADD, SH_LO, WR_NONE, 1'b0, JMP_NEXT);
         4'd12: c = cw(OPND_ZR, 1'b1, OPND_ZI, 1'b1, ACC_ADD, SH_LO, WR_NONE, 1'b0, JMP_NEXT);
         4'd13: c = cw(OPND_ZR, 1'b0, OPND_ZR, 1'b0, ACC_ADD, SH_TWO_LO, WR_NONE, 1'b0,
                       JMP_NEXT);
         4'd14: c = cw(OPND_ZR, 1'b0, OPND_ZR, 1'b0, ACC_HOLD, SH_0, WR_T, 1'b0, JMP_NEXT);
         4'd15: c = cw(OPND_ZR, 1'b0, OPND_ZR, 1'b0, ACC_HOLD, SH_0, WR_NONE, 1'b1, JMP_LOOP);
         default: c = CTRL_IDLE;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/mandelbrot_escape_iteration.sv =====
// Top level of the escape-time iteration block for one point of the complex plane.
//
// The request channel takes one point c (req_c_real, req_c_imag) per beat on
// req_valid and req_stall. The block then iterates z = z^2 + c from z = 0 until
// the square sum reaches 4 or the iteration limit is hit, and returns one beat
// on rsp_valid and rsp_stall with the escape count and the final z.
// In each iteration a microcode program runs the three products through one
// shared 19 by 19 bit multiplier as four partial products each. The next
// point is taken only after the result of the last one is registered.
// One point is worked on at a time; req_stall is high while busy.
// A finished result sits in the output register; when the receiver stalls, the
// block holds at its final test step until the register frees.
// The limit register is written through csr_valid, csr_ready and csr_data,
// and only while the block is idle. Reset sets the limit to 255 and clears all
// control state; no clearing pass is needed.
module mandelbrot_escape_iteration #(
   parameter int FRAC_BITS  = 26,
   parameter int COUNT_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [mbrot_pkg::IN_BITS-1:0] req_c_real,
   input  logic signed [mbrot_pkg::IN_BITS-1:0] req_c_imag,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mbrot_pkg::LIMIT_BITS-1:0]     rsp_escape_count,
   output logic signed [mbrot_pkg::Z_BITS-1:0]  rsp_final_real,
   output logic signed [mbrot_pkg::Z_BITS-1:0]  rsp_final_imag,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mbrot_pkg::LIMIT_BITS-1:0]     csr_data
);
   import mbrot_pkg::*;

   logic [LIMIT_BITS-1:0]    limit_ff, limit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic signed [Z_BITS-1:0] rsp_real_ff, rsp_real_in, rsp_imag_ff, rsp_imag_in;

   logic                     busy, done, start, out_free;
   ctrl_type                 ctrl;
   stat_type                 stat;
   logic [LIMIT_BITS-1:0]    dp_count;
   logic signed [Z_BITS-1:0] dp_real, dp_imag;

   assign req_stall = busy;
   assign start     = req_valid && !busy;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = !busy;

   mbrot_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .stat     (stat),
      .ctrl     (ctrl),
      .busy     (busy),
      .done     (done)
   );

   mbrot_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dp (
      .clock        (clock),
      .start        (start),
      .c_real       (req_c_real),
      .c_imag       (req_c_imag),
      .limit        (limit_ff),
      .ctrl         (ctrl),
      .stat         (stat),
      .escape_count (dp_count),
      .final_real   (dp_real),
      .final_imag   (dp_imag)
   );

   always_comb begin
      limit_in     = limit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_real_in  = rsp_real_ff;
      rsp_imag_in  = rsp_imag_ff;
      if (csr_valid && csr_ready) begin
         limit_in = csr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = dp_count;
         rsp_real_in  = dp_real;
         rsp_imag_in  = dp_imag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_count_ff <= rsp_count_in;
      rsp_real_ff  <= rsp_real_in;
      rsp_imag_ff  <= rsp_imag_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_escape_count = rsp_count_ff;
   assign rsp_final_real   = rsp_real_ff;
   assign rsp_final_imag   = rsp_imag_ff;

endmodule

// ===== rtl/mbrot_sequencer.sv =====
// Step counter and microcode table that drive the iteration datapath.
module mbrot_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               out_free,
   input  mbrot_pkg::stat_type stat,
   output mbrot_pkg::ctrl_type ctrl,
   output logic               busy,
   output logic               done
);
   import mbrot_pkg::*;

   logic                run_ff, run_in;
   logic [UPC_BITS-1:0] upc_ff, upc_in;
   ctrl_type            word;

   assign word = ucode(upc_ff);
   assign ctrl = run_ff ? word : CTRL_IDLE;
   assign busy = run_ff;
   assign done = run_ff && (word.jmp == JMP_TEST) && !stat.cont && out_free;

   always_comb begin
      run_in = run_ff;
      upc_in = upc_ff;
      if (!run_ff) begin
         if (start) begin
            run_in = 1'b1;
            upc_in = '0;
         end
      end else begin
         case (word.jmp)
            JMP_TEST: begin
               if (stat.cont) begin
                  upc_in = upc_ff + 1'b1;
               end else if (out_free) begin
                  run_in = 1'b0;
               end
            end
            JMP_LOOP: upc_in = '0;
            default:  upc_in = upc_ff + 1'b1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         upc_ff <= '0;
      end else begin
         run_ff <= run_in;
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== rtl/mbrot_datapath.sv =====
// Shared partial-product multiplier, accumulator and z registers of the iteration.
module mbrot_datapath #(
   parameter int FRAC_BITS  = 26,
   parameter int COUNT_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  start,
   input  logic signed [mbrot_pkg::IN_BITS-1:0]  c_real,
   input  logic signed [mbrot_pkg::IN_BITS-1:0]  c_imag,
   input  logic [mbrot_pkg::LIMIT_BITS-1:0]      limit,
   input  mbrot_pkg::ctrl_type                   ctrl,
   output mbrot_pkg::stat_type                   stat,
   output logic [mbrot_pkg::LIMIT_BITS-1:0]      escape_count,
   output logic signed [mbrot_pkg::Z_BITS-1:0]   final_real,
   output logic signed [mbrot_pkg::Z_BITS-1:0]   final_imag
);
   import mbrot_pkg::*;

   localparam int CW = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;
   localparam logic signed [S_BITS:0] BOUND = (S_BITS + 1)'(4) <<< FRAC_BITS;

   logic signed [Z_BITS-1:0]   zr_ff, zr_in, zi_ff, zi_in;
   logic signed [IN_BITS-1:0]  cr_ff, cr_in, ci_ff, ci_in;
   logic signed [S_BITS-1:0]   sr_ff, sr_in, si_ff, si_in, t_ff, t_in;
   logic [COUNT_BITS-1:0]      count_ff, count_in;
   logic signed [PP_BITS-1:0]  prod_ff, prod_in;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;

   logic signed [Z_BITS-1:0]   opa, opb;
   logic signed [MOP_BITS-1:0] mop_a, mop_b;
   logic signed [ACC_BITS-1:0] pp_ext, pp_sh, scaled;
   logic signed [S_BITS-1:0]   s_val;
   logic signed [SUM_BITS-1:0] re_sum, im_sum;
   logic signed [S_BITS:0]     sq_sum;
   logic                       escaped;
   logic [CW-1:0]              lim_w, cnt_w;
   logic [COUNT_BITS-1:0]      lim_c;

   function automatic logic signed [Z_BITS-1:0] sat_z(input logic signed [SUM_BITS-1:0] v);
      logic signed [Z_BITS-1:0] r;
      if (v[SUM_BITS-1:Z_BITS-1] == {(SUM_BITS-Z_BITS+1){v[SUM_BITS-1]}}) begin
         r = v[Z_BITS-1:0];
      end else if (v[SUM_BITS-1]) begin
         r = {1'b1, {(Z_BITS-1){1'b0}}};
      end else begin
         r = {1'b0, {(Z_BITS-1){1'b1}}};
      end
      return r;
   endfunction

   assign opa   = (ctrl.a_sel == OPND_ZR) ? zr_ff : zi_ff;
   assign opb   = (ctrl.b_sel == OPND_ZR) ? zr_ff : zi_ff;
   assign mop_a = ctrl.a_hi ? {{(MOP_BITS-HI_BITS){opa[Z_BITS-1]}}, opa[Z_BITS-1:LO_BITS]}
                            : {1'b0, opa[LO_BITS-1:0]};
   assign mop_b = ctrl.b_hi ? {{(MOP_BITS-HI_BITS){opb[Z_BITS-1]}}, opb[Z_BITS-1:LO_BITS]}
                            : {1'b0, opb[LO_BITS-1:0]};
   assign prod_in = mop_a * mop_b;

   assign pp_ext = {{(ACC_BITS-PP_BITS){prod_ff[PP_BITS-1]}}, prod_ff};

   always_comb begin
      case (ctrl.acc_sh)
         SH_LO:     pp_sh = pp_ext <<< LO_BITS;
         SH_TWO_LO: pp_sh = pp_ext <<< (2 * LO_BITS);
         default:   pp_sh = pp_ext;
      endcase
      case (ctrl.acc_op)
         ACC_LOAD: acc_in = pp_sh;
         ACC_ADD:  acc_in = acc_ff + pp_sh;
         default:  acc_in = acc_ff;
      endcase
   end

   assign scaled = acc_ff >>> FRAC_BITS;
   assign s_val  = scaled[S_BITS-1:0];

   assign re_sum = SUM_BITS'(sr_ff) - SUM_BITS'(si_ff) + SUM_BITS'(cr_ff);
   assign im_sum = SUM_BITS'(t_ff) + SUM_BITS'(t_ff) + SUM_BITS'(ci_ff);
   assign sq_sum = (S_BITS + 1)'(sr_ff) + (S_BITS + 1)'(si_ff);
   assign escaped = (sq_sum >= BOUND);

   assign lim_w = CW'(limit);
   assign lim_c = lim_w[COUNT_BITS-1:0];
   assign cnt_w = CW'(count_ff);

   assign stat.cont    = (count_ff < lim_c) && !escaped;
   assign escape_count = escaped ? cnt_w[LIMIT_BITS-1:0] : '0;
   assign final_real   = zr_ff;
   assign final_imag   = zi_ff;

   always_comb begin
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      sr_in    = sr_ff;
      si_in    = si_ff;
      t_in     = t_ff;
      count_in = count_ff;
      if (start) begin
         zr_in    = '0;
         zi_in    = '0;
         cr_in    = c_real;
         ci_in    = c_imag;
         sr_in    = '0;
         si_in    = '0;
         t_in     = '0;
         count_in = '0;
      end else begin
         case (ctrl.wr)
            WR_SR:   sr_in = s_val;
            WR_SI:   si_in = s_val;
            WR_T:    t_in  = s_val;
            default: ;
         endcase
         if (ctrl.upd) begin
            zr_in    = sat_z(re_sum);
            zi_in    = sat_z(im_sum);
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      sr_ff    <= sr_in;
      si_ff    <= si_in;
      t_ff     <= t_in;
      count_ff <= count_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

endmodule
